/* hw/rtl/ordered_list_delete_by_value_core_macros.svh */
// Assertion macros for the ordered list core.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ORDERED_LIST_DELETE_BY_VALUE_CORE_MACROS_SVH
`define ORDERED_LIST_DELETE_BY_VALUE_CORE_MACROS_SVH

// Check a property on every clock edge outside reset
`define OLDEL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define OLDEL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/oldel_pkg.sv */
// Shared types and codes for the ordered list core.
// Depends on nothing; imported by every module of the block.
package oldel_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned ACT_W = 2;
  localparam int unsigned ST_W  = 2;

  // Action codes of an input beat
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  // Status codes of a result beat
  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } stat_t;

endpackage

/* hw/rtl/ordered_list_delete_by_value_core.sv */
// Top level of the ordered list core: sequencer, occupancy and result register.
// Depends on oldel_pkg, oldel_ram and the assertion macro header.
//
//   channel | ports                                  | direction
//   in      | in_valid in_ready in_action in_value   | beat in
//   out     | out_valid out_ready out_status out_item out_last | beats out
//
// Append and every empty or full answer go through the status state, which posts one status beat.
// Delete walks the entries one per cycle through the memory read port.
// Readout sends one beat per entry, one per cycle while out_ready holds.
// Reset clears occupancy and control; the entry memory keeps its contents.
// A stalled result register halts the readout walk and holds the status beat of the
// other actions; the delete walk runs on. The memory read data holds meanwhile.
`include "ordered_list_delete_by_value_core_macros.svh"

module ordered_list_delete_by_value_core
  import oldel_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ACT_W-1:0]        in_action,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ST_W-1:0]         out_status,
  output logic signed [VAL_W-1:0] out_item,
  output logic                    out_last
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEL,
    S_RD,
    S_RESP
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    di_r, di_nxt;
  logic             found_r, found_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  stat_t            st_r, st_nxt;
  logic             out_valid_r, out_valid_nxt;
  stat_t            out_status_r, out_status_nxt;
  logic [VAL_W-1:0] out_item_r, out_item_nxt;
  logic             out_last_r, out_last_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  logic             out_free;
  logic             is_full;
  logic             is_empty;
  logic             at_last;
  logic             hit;

  oldel_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign is_full  = (cnt_r == CW'(DEPTH));
  assign is_empty = (cnt_r == '0);
  assign at_last  = (CW'(di_r) == cnt_r - CW'(1));
  assign hit      = (ram_rdata == val_r);
  assign in_ready = (state_r == S_IDLE);

  // Sequence each beat through the memory
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    di_nxt         = di_r;
    found_nxt      = found_r;
    val_nxt        = val_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[AW-1:0];
    ram_wdata      = in_value;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt   = in_value;
          di_nxt    = '0;
          found_nxt = 1'b0;
          unique case (in_action)
            ACT_APPEND: begin
              // Append at the tail unless full
              if (is_full) begin
                st_nxt = ST_FULL;
              end else begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
                st_nxt  = ST_OK;
              end
              state_nxt = S_RESP;
            end
            ACT_DELETE: begin
              if (is_empty) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                ram_re    = 1'b1;
                state_nxt = S_DEL;
              end
            end
            ACT_READ: begin
              if (is_empty) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                ram_re    = 1'b1;
                state_nxt = S_RD;
              end
            end
            default: begin
              // Drop the unused code
            end
          endcase
        end
      end

      S_DEL: begin
        // Past the match, move each entry up one place
        if (found_r) begin
          ram_we    = 1'b1;
          ram_waddr = di_r - AW'(1);
          ram_wdata = ram_rdata;
        end
        found_nxt = found_r || hit;
        if (at_last) begin
          if (found_r || hit) begin
            cnt_nxt = cnt_r - CW'(1);
            st_nxt  = ST_OK;
          end else begin
            st_nxt  = ST_NOTFOUND;
          end
          state_nxt = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = di_r + AW'(1);
          di_nxt    = di_r + AW'(1);
        end
      end

      S_RD: begin
        // Send one entry per beat, advance only when the result register frees
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_item_nxt   = ram_rdata;
          out_last_nxt   = at_last;
          if (at_last) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = di_r + AW'(1);
            di_nxt    = di_r + AW'(1);
          end
        end
      end

      S_RESP: begin
        // Post the single status beat
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_item_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    di_r         <= di_nxt;
    val_r        <= val_nxt;
    st_r         <= st_nxt;
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_item   = out_item_r;
  assign out_last   = out_last_r;

  `OLDEL_ASSERT(a_cnt_bound, cnt_r <= CW'(DEPTH), "occupancy above depth")
  `OLDEL_ASSERT(a_full_keeps, (in_valid && in_ready && in_action == ACT_APPEND && is_full) |=> $stable(cnt_r), "append to full list changed occupancy")
  `OLDEL_ASSERT(a_status_item, (out_valid_r && out_status_r != ST_OK) |-> (out_item_r == '0 && out_last_r), "status beat with item or without last")
  `OLDEL_ASSERT(a_port_clash, (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "shift write hits the entry being read")
  `OLDEL_ASSERT(a_cnt_where, (state_r == S_RD || state_r == S_RESP) |=> $stable(cnt_r), "occupancy moved outside append or delete")

endmodule

/* hw/rtl/oldel_ram.sv */
// Entry store of the ordered list: one write port, one read port.
// Depends on oldel_pkg for the entry width.
module oldel_ram
  import oldel_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [VAL_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; hold the data while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* tb/ordered_list_delete_by_value_core_tb.sv */
// Testbench for ordered_list_delete_by_value_core: a directed table, then random beats,
// checked beat by beat against a behavioral model of the list kept in this file (typed rows: their own status).
// Depends on oldel_pkg and the core RTL only.
module ordered_list_delete_by_value_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oldel_pkg::*;

  localparam int unsigned LIST_DEPTH   = 16;
  localparam int unsigned RANDOM_BEATS = 146;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // One result beat as the list should produce it
  typedef struct packed {
    stat_t            status;
    logic [VAL_W-1:0] item;
    logic             last;
  } list_result_t;

  // One row of the directed table; a typed row carries its own status,
  // with item zero and last set, and repeats with value + k
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [VAL_W-1:0] value;
    logic [4:0]       reps;
    logic             typed;
    stat_t            status;
  } directed_row_t;

  localparam int unsigned N_ROWS = 22;

  directed_row_t directed_rows [N_ROWS] = '{
    '{ACT_READ,   32'h0000_0000, 5'd1,  1'b1, ST_EMPTY},
    '{ACT_DELETE, 32'h0000_0005, 5'd1,  1'b1, ST_EMPTY},
    '{ACT_APPEND, 32'h8000_0000, 5'd1,  1'b1, ST_OK},
    '{ACT_APPEND, 32'h7FFF_FFFF, 5'd1,  1'b1, ST_OK},
    '{ACT_APPEND, 32'h0000_0000, 5'd1,  1'b1, ST_OK},
    '{ACT_APPEND, 32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK},
    '{ACT_DELETE, 32'h0000_0001, 5'd1,  1'b1, ST_NOTFOUND},
    '{ACT_READ,   32'hFFFF_FFFF, 5'd1,  1'b0, ST_OK},
    '{ACT_UNUSED, 32'hA5A5_A5A5, 5'd1,  1'b0, ST_OK},
    '{ACT_DELETE, 32'h8000_0000, 5'd1,  1'b1, ST_OK},
    '{ACT_DELETE, 32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK},
    '{ACT_READ,   32'h5A5A_5A5A, 5'd1,  1'b0, ST_OK},
    '{ACT_APPEND, 32'h0000_0007, 5'd1,  1'b1, ST_OK},
    '{ACT_APPEND, 32'h0000_0007, 5'd1,  1'b1, ST_OK},
    '{ACT_DELETE, 32'h0000_0007, 5'd1,  1'b1, ST_OK},
    '{ACT_READ,   32'h0000_0000, 5'd1,  1'b0, ST_OK},
    '{ACT_APPEND, 32'h0000_0064, 5'd13, 1'b1, ST_OK},
    '{ACT_APPEND, 32'h0000_0005, 5'd1,  1'b1, ST_FULL},
    '{ACT_READ,   32'h0000_0000, 5'd1,  1'b0, ST_OK},
    '{ACT_DELETE, 32'h0000_006A, 5'd1,  1'b1, ST_OK},
    '{ACT_DELETE, 32'h0000_006A, 5'd1,  1'b1, ST_NOTFOUND},
    '{ACT_APPEND, 32'hFFFF_FFFB, 5'd1,  1'b1, ST_OK}
  };

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [ACT_W-1:0]        in_action;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_ready;
  logic [ST_W-1:0]         out_status;
  logic signed [VAL_W-1:0] out_item;
  logic                    out_last;

  // Shadow copy of the list, front at index 0
  logic [VAL_W-1:0] shadow_vals [LIST_DEPTH];
  int unsigned      shadow_len;

  list_result_t expected_results [$];
  int unsigned  mismatches;
  bit           calm_in;
  bit           calm_out;

  ordered_list_delete_by_value_core #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_status(out_status),
    .out_item  (out_item),
    .out_last  (out_last)
  );

  always #5 clk = ~clk;

  // Apply one action to the shadow list and return the beats it should give
  function automatic void list_step(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val,
                                    output list_result_t res[$]);
    int pos;
    res = {};
    pos = -1;
    case (act)
      ACT_APPEND: begin
        if (shadow_len >= LIST_DEPTH) begin
          res.push_back('{status: ST_FULL, item: '0, last: 1'b1});
        end else begin
          shadow_vals[shadow_len] = val;
          shadow_len++;
          res.push_back('{status: ST_OK, item: '0, last: 1'b1});
        end
      end
      ACT_DELETE: begin
        if (shadow_len == 0) begin
          res.push_back('{status: ST_EMPTY, item: '0, last: 1'b1});
        end else begin
          for (int i = 0; i < shadow_len; i++) begin
            if (pos < 0 && shadow_vals[i] == val) pos = i;
          end
          if (pos < 0) begin
            res.push_back('{status: ST_NOTFOUND, item: '0, last: 1'b1});
          end else begin
            // close the gap behind the removed entry
            for (int i = pos; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i+1];
            shadow_len--;
            res.push_back('{status: ST_OK, item: '0, last: 1'b1});
          end
        end
      end
      ACT_READ: begin
        if (shadow_len == 0) begin
          res.push_back('{status: ST_EMPTY, item: '0, last: 1'b1});
        end else begin
          for (int i = 0; i < shadow_len; i++) begin
            res.push_back('{status: ST_OK, item: shadow_vals[i], last: (i + 1 == shadow_len)});
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Drive one input beat, hold it until accepted, then queue its results
  task automatic send_beat(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val,
                           input bit typed, input stat_t st);
    list_result_t produced [$];
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action = act;
    in_value  = val;
    in_valid  = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    list_step(act, val, produced);
    if (typed) begin
      expected_results.push_back('{status: st, item: '0, last: 1'b1});
    end else begin
      foreach (produced[k]) expected_results.push_back(produced[k]);
    end
    @(negedge clk);
  endtask

  // Hold the sender off until every queued result has come back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = VAL_W'($signed($urandom_range(0, 4)) - 2);
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Pick a value stored in the list so deletes hit, else a random one
  function automatic logic [VAL_W-1:0] stored_value();
    if (shadow_len == 0) return pick_value();
    return shadow_vals[$urandom_range(0, shadow_len - 1)];
  endfunction

  // Check every accepted result beat against the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat status %0d item %0d last %0d",
                 $time, out_status, out_item, out_last);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          mismatches++;
        end
        if (out_item !== want.item) begin
          $display("%0t: item expected %0d actual %0d", $time,
                   $signed(want.item), out_item);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  // Result side: at random, stall before taking each beat; calm stretches never stall
  initial begin
    int stall;
    int taken;
    out_ready = 1'b0;
    calm_out  = 1'b0;
    taken     = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (taken % 24 == 0) calm_out = ($urandom_range(0, 3) == 0);
      stall = calm_out ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  // Stop a hung run
  initial begin
    #(2_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus: reset, directed table, random beats, drain
  initial begin
    int roll;
    int sent;
    bit filling;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = ACT_APPEND;
    in_value    = '0;
    shadow_len  = 0;
    mismatches  = 0;
    calm_in     = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // walk the directed table
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_beat(directed_rows[r].action, directed_rows[r].value + VAL_W'(k),
                  directed_rows[r].typed, directed_rows[r].status);
      end
    end
    wait_drained();

    // random beats: alternate fill and drain phases so the list swings
    // between empty and full
    sent    = 0;
    filling = 1'b0;
    while (sent < RANDOM_BEATS) begin
      if (sent % 30 == 0) filling = ~filling;
      calm_in = ((sent / 20) % 4 == 3);
      if (sent == RANDOM_BEATS / 2) wait_drained();
      roll = $urandom_range(0, 99);
      if (roll >= 95) begin
        send_beat(ACT_UNUSED, pick_value(), 1'b0, ST_OK);
      end else begin
        if (filling) begin
          if (roll < 55)      send_beat(ACT_APPEND, pick_value(), 1'b0, ST_OK);
          else if (roll < 70) send_beat(ACT_DELETE, stored_value(), 1'b0, ST_OK);
          else if (roll < 78) send_beat(ACT_DELETE, pick_value(), 1'b0, ST_OK);
          else                send_beat(ACT_READ, pick_value(), 1'b0, ST_OK);
        end else begin
          if (roll < 15)      send_beat(ACT_APPEND, pick_value(), 1'b0, ST_OK);
          else if (roll < 60) send_beat(ACT_DELETE, stored_value(), 1'b0, ST_OK);
          else if (roll < 70) send_beat(ACT_DELETE, pick_value(), 1'b0, ST_OK);
          else                send_beat(ACT_READ, pick_value(), 1'b0, ST_OK);
        end
      end
      sent++;
    end
    in_valid = 1'b0;

    // drain, then allow for a full walk of stray output
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3 * LIST_DEPTH) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
